>>> hdl/ippe_pkg.sv
package ippe_pkg;

  // Input command codes, carried on tuser
  localparam logic CMD_PALETTE_WRITE = 1'b0;
  localparam logic CMD_PIXEL_DATA    = 1'b1;

  // Configuration register indexes
  localparam logic CFG_PIXEL_FMT    = 1'b0;
  localparam logic CFG_IMAGE_WIDTH  = 1'b1;
  localparam int   CFG_DATA_W       = 13;

  // Colour format codes
  localparam logic [1:0] FMT_1BPP = 2'd0;
  localparam logic [1:0] FMT_2BPP = 2'd1;
  localparam logic [1:0] FMT_4BPP = 2'd2;
  localparam logic [1:0] FMT_8BPP = 2'd3;

  localparam int COLOR_W   = 32;
  localparam int INDEX_W   = 8;
  localparam int IN_DATA_W = 48;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  // One classified item: for a palette write, addr is the entry and data the colour;
  // for a pixel byte, addr holds the packed byte.
  typedef struct packed {
    kind_t               kind;
    logic [INDEX_W-1:0]  addr;
    logic [COLOR_W-1:0]  data;
  } queue_entry_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               row_end;
    logic               last;
  } out_word_t;

endpackage

>>> hdl/ippe_ram.sv
module ippe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/ippe_front.sv
module ippe_front #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ippe_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  input  logic                             q_full,
  output logic                             q_push,
  output ippe_pkg::queue_entry_t           q_entry
);

  logic [ippe_pkg::INDEX_W-1:0] wr_index;
  logic                         index_ok;

  assign wr_index  = in_tdata[7:0];
  assign index_ok  = {1'b0, wr_index} < 9'(PALETTE_DEPTH);
  assign in_tready = !q_full;

  always_comb begin
    q_entry = '0;
    q_push  = 1'b0;
    case (in_tuser)
      ippe_pkg::CMD_PALETTE_WRITE: begin
        q_entry.kind = ippe_pkg::KIND_WRITE;
        q_entry.addr = wr_index;
        q_entry.data = in_tdata[39:8];
        // Writes beyond the palette have no effect, so they never enter the queue.
        q_push       = in_tvalid && !q_full && index_ok;
      end
      ippe_pkg::CMD_PIXEL_DATA: begin
        q_entry.kind = ippe_pkg::KIND_PIXEL;
        q_entry.addr = in_tdata[47:40];
        q_push       = in_tvalid && !q_full;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/ippe_queue.sv
module ippe_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  ippe_pkg::queue_entry_t  push_entry,
  output logic                    full,
  input  logic                    pop,
  output ippe_pkg::queue_entry_t  head,
  output logic                    not_empty
);

  ippe_pkg::queue_entry_t       ent_r [ippe_pkg::QDEPTH];
  logic [ippe_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ippe_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ippe_pkg::QAW:0]       cnt_r, cnt_nxt;

  assign full      = cnt_r == (ippe_pkg::QAW+1)'(ippe_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (ippe_pkg::QAW+1)'(push) - (ippe_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

  chk_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue pushed while full");
  chk_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue popped while empty");
  chk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");

endmodule

>>> hdl/ippe_back.sv
module ippe_back #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [ippe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  ippe_pkg::queue_entry_t            q_head,
  input  logic                              q_valid,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ippe_pkg::COLOR_W-1:0]      out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration
  logic [1:0]    format_r;
  logic [WW-1:0] width_r;
  logic [WW-1:0] width_clamped;

  always_comb begin
    if (cfg_wdata == '0) begin
      width_clamped = WW'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = WW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= ippe_pkg::FMT_8BPP;
      width_r  <= WW'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        ippe_pkg::CFG_PIXEL_FMT:    format_r <= cfg_wdata[1:0];
        ippe_pkg::CFG_IMAGE_WIDTH:  width_r  <= width_clamped;
        default: ;
      endcase
    end
  end

  // Unpacking state
  logic          busy_r, busy_nxt;
  logic [7:0]    sh_r, sh_nxt;
  logic [3:0]    left_r, left_nxt;
  logic [CW-1:0] col_r, col_nxt;

  // Palette read stage and output buffer
  logic                        s1_valid_r, s1_zero_r, s1_row_end_r, s1_last_r;
  logic [ippe_pkg::COLOR_W-1:0] ram_rdata;
  ippe_pkg::out_word_t         ob_r [2];
  ippe_pkg::out_word_t         ob_push;
  logic                        ob_wr_r, ob_rd_r;
  logic [1:0]                  ob_cnt_r;
  logic                        out_pop;

  logic [7:0]    idx;
  logic [7:0]    sh_shifted;
  logic [3:0]    fields_load;
  logic          idx_ok;
  logic          room;
  logic          issue;
  logic          row_done;
  logic          last_field;
  logic          free;
  logic          pop_pixel, pop_write;
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;

  always_comb begin
    case (format_r)
      ippe_pkg::FMT_1BPP: begin
        idx = {7'd0, sh_r[7]};
        sh_shifted = {sh_r[6:0], 1'b0};
        fields_load = 4'd8;
      end
      ippe_pkg::FMT_2BPP: begin
        idx = {6'd0, sh_r[7:6]};
        sh_shifted = {sh_r[5:0], 2'b00};
        fields_load = 4'd4;
      end
      ippe_pkg::FMT_4BPP: begin
        idx = {4'd0, sh_r[7:4]};
        sh_shifted = {sh_r[3:0], 4'd0};
        fields_load = 4'd2;
      end
      default: begin
        idx = sh_r;
        sh_shifted = 8'd0;
        fields_load = 4'd1;
      end
    endcase
  end

  assign idx_ok     = {1'b0, idx} < 9'(PALETTE_DEPTH);
  // Issue only when the output buffer is sure to have space when the read returns.
  assign out_pop    = out_tvalid && out_tready;
  assign room       = (3'(ob_cnt_r) + 3'(s1_valid_r)) < (3'd2 + 3'(out_pop));
  assign issue      = busy_r && room;
  assign row_done   = ((WW+1)'(col_r) + (WW+1)'(1)) >= {1'b0, width_r};
  assign last_field = row_done || (left_r == 4'd1);
  assign free       = !busy_r || (issue && last_field);
  assign pop_pixel  = q_valid && free && (q_head.kind == ippe_pkg::KIND_PIXEL);
  assign pop_write  = q_valid && !busy_r && (q_head.kind == ippe_pkg::KIND_WRITE);
  assign q_pop      = pop_pixel || pop_write;

  always_comb begin
    busy_nxt = busy_r;
    sh_nxt   = sh_r;
    left_nxt = left_r;
    col_nxt  = col_r;
    if (issue) begin
      sh_nxt   = sh_shifted;
      left_nxt = left_r - 4'd1;
      col_nxt  = row_done ? '0 : col_r + 1'b1;
      if (last_field) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop_pixel) begin
      busy_nxt = 1'b1;
      sh_nxt   = q_head.addr;
      left_nxt = fields_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    sh_r         <= sh_nxt;
    left_r       <= left_nxt;
    s1_zero_r    <= !idx_ok;
    s1_row_end_r <= row_done;
    s1_last_r    <= last_field;
  end

  assign ram_we   = pop_write;
  assign ram_en   = issue;
  assign ram_addr = pop_write ? q_head.addr[AW-1:0] : idx[AW-1:0];

  ippe_ram #(
    .WIDTH(ippe_pkg::COLOR_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_head.data),
    .rdata (ram_rdata)
  );

  assign ob_push.color   = s1_zero_r ? '0 : ram_rdata;
  assign ob_push.row_end = s1_row_end_r;
  assign ob_push.last    = s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (s1_valid_r) begin
        ob_wr_r <= !ob_wr_r;
      end
      if (out_pop) begin
        ob_rd_r <= !ob_rd_r;
      end
      ob_cnt_r <= ob_cnt_r + 2'(s1_valid_r) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      ob_r[ob_wr_r] <= ob_push;
    end
  end

  assign out_tvalid = ob_cnt_r != 2'd0;
  assign out_tdata  = ob_r[ob_rd_r].color;
  assign out_tlast  = ob_r[ob_rd_r].row_end;
  assign out_tuser  = ob_r[ob_rd_r].last;

  chk_buffer_space: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (ob_cnt_r < 2'd2 || out_pop)) else $error("output buffer overrun");
  chk_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_en)) else $error("palette written and read in one cycle");
  chk_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && row_done) |=> col_r == '0) else $error("column not cleared at row end");
  chk_busy_fields: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> left_r != 4'd0) else $error("busy with no fields left");

endmodule

>>> hdl/indexed_palette_pixel_expander_unit.sv
// Channel | Direction | tdata (low bit up)                                  | tlast   | tuser
// in_     | in        | palette_index[7:0], palette_color[39:8], data_byte[47:40] | -  | command
// out_    | out       | pixel_color[31:0]                                   | row_end | last_of_byte
// cfg_    | in        | write: cfg_addr 0 = bits per index, 1 = image_width | -       | -
//
// A pixel byte yields 8, 4, 2 or 1 pixels for 1, 2, 4 or 8 bit formats, fewer when a row
// ends inside it: the single palette read port yields one pixel a cycle when buffer room allows.
// A palette write is done when popped; pixels pass the palette read stage and output buffer.
// Reset clears control state, sets 8 bit format and width 1; the palette is not cleared.
// A four-word queue and a two-word output buffer let either side stall independently.
module indexed_palette_pixel_expander_unit #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [ippe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // palette_index [7:0], palette_color [39:8], data_byte [47:40]
  input  logic [ippe_pkg::IN_DATA_W-1:0]   in_tdata,
  // command
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pixel_color [31:0]
  output logic [ippe_pkg::COLOR_W-1:0]     out_tdata,
  output logic                             out_tlast,
  // last_of_byte
  output logic                             out_tuser
);

  ippe_pkg::queue_entry_t push_entry, head;
  logic                   q_full, q_push, q_pop, q_valid;

  ippe_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  ippe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head),
    .not_empty  (q_valid)
  );

  ippe_back #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_head     (head),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
